// ===== design/aqsl_pkg.sv =====
package aqsl_pkg;

  localparam int AGE_BITS = 20;
  localparam int TIMEOUT_BITS = 20;
  localparam int CMP_BITS = (AGE_BITS > TIMEOUT_BITS) ? AGE_BITS : TIMEOUT_BITS;
  localparam int PPM_BITS = 16;
  localparam int SEQ_BITS = 32;
  localparam int BLINK_BITS = 16;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 20;
  localparam int IN_DATA_BITS = 56;
  localparam int OUT_DATA_BITS = 8;

  typedef logic [2:0] colour_t;

  localparam colour_t COL_OFF    = 3'b000;
  localparam colour_t COL_BLUE   = 3'b001;
  localparam colour_t COL_GREEN  = 3'b010;
  localparam colour_t COL_RED    = 3'b100;
  localparam colour_t COL_YELLOW = 3'b110;

  localparam logic [CFG_IDX_BITS-1:0] REG_GREEN_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_YELLOW_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_OFFLINE_TIMEOUT = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_PERIOD  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_POLARITY      = 3'd4;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_SAMPLE = 1'b1;

  typedef struct packed {
    logic booting;
    logic offline;
    logic changed;
    logic blue_level;
    logic green_level;
    logic red_level;
  } result_t;

endpackage

// ===== design/air_quality_status_led_top.sv =====
// Air quality status LED.
// Input channel in_*: one word per event. in_tuser carries action (0: a millisecond
// tick, 1: a CO2 sample). in_tdata carries, from bit 0 up, sample_valid, co2_ppm
// (16 bits) and sample_seq (32 bits), padded with zeros to 56 bits.
// Output channel out_*: one result word per input word, carrying from bit 0 up
// red_level, green_level, blue_level, changed, offline and booting.
// The configuration port writes the colour thresholds, the offline timeout, the
// blink period and the pin polarity; the user must do this only while the block
// is idle, as the block does not enforce it. Each result is registered, into the
// skid buffer if the output is stalled. Throughput is one word per cycle while
// in_tready is high; the counter and compare updates of a word are combinational,
// so the state registers are ready for the next. A two-entry output buffer
// decouples the channels: in_tready depends only on the buffer fill, so a stalled
// receiver holds back the sender after two words. Reset restores the configuration
// defaults, empties the output buffer and returns the LED to booting, showing blue.
module air_quality_status_led_top import aqsl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_tvalid,
  output logic                     in_tready,
  // Fields from bit 0: sample_valid, co2_ppm, sample_seq, zero padding.
  input  logic [IN_DATA_BITS-1:0]  in_tdata,
  // Fields from bit 0: action.
  input  logic                     in_tuser,
  output logic                     out_tvalid,
  input  logic                     out_tready,
  // Fields from bit 0: red_level, green_level, blue_level, changed, offline, booting,
  // zero padding.
  output logic [OUT_DATA_BITS-1:0] out_tdata,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  logic [PPM_BITS-1:0]     green_limit_r;
  logic [PPM_BITS-1:0]     yellow_limit_r;
  logic [TIMEOUT_BITS-1:0] timeout_r;
  logic [BLINK_BITS-1:0]   period_r;
  logic                    led_on_high_r;

  logic                  boot_r, boot_nxt;
  logic [SEQ_BITS-1:0]   prev_seq_r, prev_seq_nxt;
  logic [AGE_BITS-1:0]   age_r, age_nxt;
  logic [BLINK_BITS-1:0] blink_r, blink_nxt;
  logic                  phase_r, phase_nxt;
  colour_t               goal_r, goal_nxt;
  colour_t               shown_r, shown_nxt;

  logic                  in_action, in_valid;
  logic [PPM_BITS-1:0]   in_ppm;
  logic [SEQ_BITS-1:0]   in_seq;
  logic                  accept, pop, take, offline, toggle;
  logic [AGE_BITS-1:0]   age_inc;
  logic [BLINK_BITS-1:0] blink_inc;
  colour_t               classed;
  result_t               res;

  logic    out_valid_r, skid_valid_r;
  result_t out_data_r, skid_data_r;

  assign in_action = in_tuser;
  assign in_valid  = in_tdata[0];
  assign in_ppm    = in_tdata[PPM_BITS:1];
  assign in_seq    = in_tdata[PPM_BITS+SEQ_BITS:PPM_BITS+1];

  assign in_tready  = !skid_valid_r;
  assign accept     = in_tvalid && in_tready;
  assign pop        = out_valid_r && out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_BITS-6){1'b0}}, out_data_r};

  always_comb begin
    if (in_ppm < green_limit_r) begin
      classed = COL_GREEN;
    end else if (in_ppm < yellow_limit_r) begin
      classed = COL_YELLOW;
    end else begin
      classed = COL_RED;
    end
  end

  always_comb begin
    age_inc   = (age_r != '1) ? age_r + 1'b1 : age_r;
    blink_inc = (blink_r != '1) ? blink_r + 1'b1 : blink_r;
    take = (in_action == ACT_SAMPLE) && in_valid && (in_ppm != '0) &&
           (boot_r || (in_seq != prev_seq_r));

    age_nxt      = age_r;
    blink_nxt    = blink_r;
    boot_nxt     = boot_r;
    prev_seq_nxt = prev_seq_r;
    goal_nxt     = goal_r;
    if (in_action == ACT_TICK) begin
      age_nxt   = age_inc;
      blink_nxt = blink_inc;
    end else if (take) begin
      boot_nxt     = 1'b0;
      prev_seq_nxt = in_seq;
      age_nxt      = '0;
      goal_nxt     = classed;
    end

    offline = !boot_nxt &&
              (CMP_BITS'(age_nxt) > CMP_BITS'(timeout_r));
    toggle  = offline && (blink_nxt >= period_r);
    phase_nxt = phase_r ^ toggle;
    if (toggle) begin
      blink_nxt = '0;
    end

    if (boot_nxt) begin
      shown_nxt = COL_BLUE;
    end else if (offline) begin
      if (toggle) begin
        shown_nxt = phase_nxt ? COL_BLUE : COL_OFF;
      end else begin
        shown_nxt = shown_r;
      end
    end else begin
      shown_nxt = goal_nxt;
    end

    res.red_level   = shown_nxt[2] ~^ led_on_high_r;
    res.green_level = shown_nxt[1] ~^ led_on_high_r;
    res.blue_level  = shown_nxt[0] ~^ led_on_high_r;
    res.changed     = (shown_nxt != shown_r);
    res.offline     = offline;
    res.booting     = boot_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      green_limit_r  <= PPM_BITS'(800);
      yellow_limit_r <= PPM_BITS'(1200);
      timeout_r      <= TIMEOUT_BITS'(15000);
      period_r       <= BLINK_BITS'(800);
      led_on_high_r  <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_GREEN_LIMIT:     green_limit_r  <= cfg_wdata[PPM_BITS-1:0];
        REG_YELLOW_LIMIT:    yellow_limit_r <= cfg_wdata[PPM_BITS-1:0];
        REG_OFFLINE_TIMEOUT: timeout_r      <= cfg_wdata[TIMEOUT_BITS-1:0];
        REG_BLINK_PERIOD:    period_r       <= cfg_wdata[BLINK_BITS-1:0];
        REG_POLARITY:        led_on_high_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      boot_r     <= 1'b1;
      prev_seq_r <= '0;
      age_r      <= '0;
      blink_r    <= '1;
      phase_r    <= 1'b0;
      goal_r     <= COL_BLUE;
      shown_r    <= COL_BLUE;
    end else if (accept) begin
      boot_r     <= boot_nxt;
      prev_seq_r <= prev_seq_nxt;
      age_r      <= age_nxt;
      blink_r    <= blink_nxt;
      phase_r    <= phase_nxt;
      goal_r     <= goal_nxt;
      shown_r    <= shown_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (!out_valid_r) begin
      if (accept) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res;
      end
    end else if (pop) begin
      if (skid_valid_r) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end else if (accept) begin
        out_data_r <= res;
      end else begin
        out_valid_r <= 1'b0;
      end
    end else if (accept) begin
      skid_valid_r <= 1'b1;
      skid_data_r  <= res;
    end
  end

endmodule

// ===== design/aqsl_checker.sv =====
module aqsl_checker import aqsl_pkg::*; (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_tready,
  input logic                     out_tvalid,
  input logic                     out_tready,
  input logic [OUT_DATA_BITS-1:0] out_tdata
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled output word changed");

  a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with an empty output");

  a_boot_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[5] && out_tdata[4]))
    else $error("booting and offline flagged together");

  a_boot_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[5] |-> !out_tdata[3])
    else $error("colour changed while booting");

endmodule

bind air_quality_status_led_top aqsl_checker u_aqsl_checker (.*);

// ===== test/tb.sv =====
module tb import aqsl_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  class led_scoreboard;
    logic [PPM_BITS-1:0]     green_limit;
    logic [PPM_BITS-1:0]     yellow_limit;
    logic [TIMEOUT_BITS-1:0] offline_timeout;
    logic [BLINK_BITS-1:0]   blink_period;
    logic                    on_high;

    logic                    boot_wait;
    logic [SEQ_BITS-1:0]     prev_seq;
    logic [AGE_BITS-1:0]     sample_age;
    logic [BLINK_BITS-1:0]   blink_age;
    logic                    blink_phase;
    colour_t                 target;
    colour_t                 shown;

    result_t                 led_q[$];
    int                      errors;

    function new();
      green_limit     = 16'd800;
      yellow_limit    = 16'd1200;
      offline_timeout = 20'd15000;
      blink_period    = 16'd800;
      on_high         = 1'b1;
      boot_wait       = 1'b1;
      prev_seq        = '0;
      sample_age      = '0;
      blink_age       = '1;
      blink_phase     = 1'b0;
      target          = COL_BLUE;
      shown           = COL_BLUE;
      errors          = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
      case (idx)
        REG_GREEN_LIMIT:     green_limit = data[PPM_BITS-1:0];
        REG_YELLOW_LIMIT:    yellow_limit = data[PPM_BITS-1:0];
        REG_OFFLINE_TIMEOUT: offline_timeout = data[TIMEOUT_BITS-1:0];
        REG_BLINK_PERIOD:    blink_period = data[BLINK_BITS-1:0];
        REG_POLARITY:        on_high = data[0];
        default: ;
      endcase
    endfunction

    function int pending();
      return led_q.size();
    endfunction

    function colour_t grade(logic [PPM_BITS-1:0] ppm);
      if (ppm < green_limit) return COL_GREEN;
      if (ppm < yellow_limit) return COL_YELLOW;
      return COL_RED;
    endfunction

    function logic show(colour_t c);
      if (c == shown) return 1'b0;
      shown = c;
      return 1'b1;
    endfunction

    function logic level(logic on);
      return on_high ? on : ~on;
    endfunction

    function void note_input(logic action, logic valid, logic [PPM_BITS-1:0] ppm,
                             logic [SEQ_BITS-1:0] seq);
      result_t r;
      logic    changed;
      logic    offline;
      changed = 1'b0;
      offline = 1'b0;
      if (action == ACT_TICK) begin
        if (sample_age != '1) sample_age = sample_age + 1'b1;
        if (blink_age != '1) blink_age = blink_age + 1'b1;
      end else if (valid && ppm != '0) begin
        if (boot_wait || seq != prev_seq) begin
          boot_wait  = 1'b0;
          prev_seq   = seq;
          sample_age = '0;
          target     = grade(ppm);
        end
      end
      if (boot_wait) begin
        changed = show(COL_BLUE);
      end else begin
        offline = sample_age > offline_timeout;
        if (offline) begin
          if (blink_age >= blink_period) begin
            blink_age   = '0;
            blink_phase = ~blink_phase;
            changed     = show(blink_phase ? COL_BLUE : COL_OFF);
          end
        end else begin
          changed = show(target);
        end
      end
      r.red_level   = level(shown[2]);
      r.green_level = level(shown[1]);
      r.blue_level  = level(shown[0]);
      r.changed     = changed;
      r.offline     = offline;
      r.booting     = boot_wait;
      led_q.push_back(r);
    endfunction

    function int compare_bit(string name, logic want, logic got);
      if (got !== want) begin
        $display("%0t: %s expected %b, got %b", $time, name, want, got);
        return 1;
      end
      return 0;
    endfunction

    function void check_result(logic [OUT_DATA_BITS-1:0] data);
      result_t want;
      result_t got;
      if (led_q.size() == 0) begin
        $display("%0t: result word %b arrived with none expected, got %b", $time, data, data);
        errors++;
        return;
      end
      want = led_q.pop_front();
      got  = result_t'(data[5:0]);
      errors += compare_bit("red_level", want.red_level, got.red_level);
      errors += compare_bit("green_level", want.green_level, got.green_level);
      errors += compare_bit("blue_level", want.blue_level, got.blue_level);
      errors += compare_bit("changed", want.changed, got.changed);
      errors += compare_bit("offline", want.offline, got.offline);
      errors += compare_bit("booting", want.booting, got.booting);
      if (data[OUT_DATA_BITS-1:6] !== '0) begin
        $display("%0t: padding expected 0, got %b", $time, data[OUT_DATA_BITS-1:6]);
        errors++;
      end
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_tvalid = 1'b0;
  logic                     in_tready;
  logic [IN_DATA_BITS-1:0]  in_tdata = '0;
  logic                     in_tuser = 1'b0;
  logic                     out_tvalid;
  logic                     out_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] out_tdata;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  led_scoreboard sb = new();

  int                  send_idle_pct = 36;
  int                  recv_idle_pct = 79;
  int                  tick_pct = 60;
  bit                  hold_request = 1'b0;
  int                  hold_left = 0;
  logic [SEQ_BITS-1:0] prev_seq_sent = '0;

  air_quality_status_led_top uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (out_tvalid === 1'b1 && out_tready === 1'b1) sb.check_result(out_tdata);
    if (hold_request) begin
      hold_left = 64;
      hold_request = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_word(logic action, logic valid, logic [PPM_BITS-1:0] ppm,
                           logic [SEQ_BITS-1:0] seq);
    logic [IN_DATA_BITS-1:0] word;
    word = '0;
    word[0] = valid;
    word[PPM_BITS:1] = ppm;
    word[PPM_BITS+SEQ_BITS:PPM_BITS+1] = seq;
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= action;
    in_tdata  <= word;
    do @(posedge clk); while (in_tready !== 1'b1);
    sb.note_input(action, valid, ppm, seq);
  endtask

  task automatic sample(logic valid, logic [PPM_BITS-1:0] ppm, logic [SEQ_BITS-1:0] seq);
    send_word(ACT_SAMPLE, valid, ppm, seq);
  endtask

  task automatic tick();
    send_word(ACT_TICK, 1'($urandom_range(1)), PPM_BITS'($urandom), SEQ_BITS'($urandom));
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
  endtask

  task automatic apply_config(int g, int y, int t, int b, int a);
    logic [CFG_IDX_BITS-1:0] stray;
    stray = REG_POLARITY + CFG_IDX_BITS'(1 + $urandom_range(2));
    wait_drained();
    repeat (3) @(posedge clk);
    write_reg(REG_GREEN_LIMIT, CFG_DATA_BITS'(g));
    write_reg(REG_YELLOW_LIMIT, CFG_DATA_BITS'(y));
    write_reg(stray, CFG_DATA_BITS'($urandom));
    write_reg(REG_OFFLINE_TIMEOUT, CFG_DATA_BITS'(t));
    write_reg(REG_BLINK_PERIOD, CFG_DATA_BITS'(b));
    write_reg(REG_POLARITY, CFG_DATA_BITS'(a));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_item();
    logic                valid;
    logic [PPM_BITS-1:0] ppm;
    logic [SEQ_BITS-1:0] seq;
    int                  pick;
    int                  base;
    valid = ($urandom_range(99) < 85);
    pick  = $urandom_range(99);
    if (pick < 8) begin
      ppm = '0;
    end else if (pick < 40) begin
      ppm = PPM_BITS'($urandom);
    end else begin
      base = $urandom_range(1) ? int'(sb.green_limit) : int'(sb.yellow_limit);
      base = base + int'($urandom_range(6)) - 3;
      if (base < 0) base = 0;
      if (base > 65535) base = 65535;
      ppm = PPM_BITS'(base);
    end
    seq = ($urandom_range(99) < 15) ? prev_seq_sent : SEQ_BITS'($urandom);
    if ($urandom_range(99) < tick_pct) begin
      send_word(ACT_TICK, valid, ppm, seq);
    end else begin
      prev_seq_sent = seq;
      sample(valid, ppm, seq);
    end
  endtask

  initial begin
    #10ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: boot, ignored samples, first sample on the reset sequence number.
    tick();
    sample(1'b0, 16'd500, 32'd5);
    sample(1'b1, 16'd0, 32'd6);
    sample(1'b1, 16'hFFFF, 32'd0);
    sample(1'b1, 16'd1, 32'd0);
    sample(1'b1, 16'd1, 32'hFFFF_FFFF);
    sample(1'b1, 16'd799, 32'd1);
    sample(1'b1, 16'd800, 32'd2);
    sample(1'b1, 16'd1199, 32'd3);
    sample(1'b1, 16'd1200, 32'd4);
    tick();

    // Zero timeout and zero blink period: the phase toggles on every word while offline; a new sample stops it.
    apply_config(800, 1200, 0, 0, 0);
    tick();
    tick();
    tick();
    sample(1'b1, 16'd100, 32'd7);
    sample(1'b0, 16'd0, 32'd7);

    // No band below zero, so everything is red; a maximal period does not blink here.
    apply_config(0, 0, 2, 65535, 1);
    sample(1'b1, 16'd1, 32'd8);
    tick();
    tick();
    tick();

    apply_config(65535, 65535, 1048574, 65535, 1);
    sample(1'b1, 16'd65534, 32'd9);
    sample(1'b1, 16'd65535, 32'd10);
    tick();

    // Yellow limit below green leaves no yellow band.
    apply_config(1200, 800, 10, 3, 0);
    sample(1'b1, 16'd1000, 32'd11);
    sample(1'b1, 16'd1199, 32'd12);

    for (int p = 0; p < 12; p++) begin
      if (p < 4) begin
        send_idle_pct = 36;
        recv_idle_pct = 79;
      end else if (p < 8) begin
        send_idle_pct = 79;
        recv_idle_pct = 36;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      tick_pct = $urandom_range(50, 92);
      case (p)
        0: apply_config(800, 1200, 15000, 800, 1);
        1: apply_config(800, 1200, 20, 5, 1);
        2: apply_config(0, 0, 3, 0, 0);
        4: apply_config(65535, 65535, 1048574, 65535, 1);
        5: apply_config(1200, 800, 10, 3, 0);
        6: apply_config(500, 1500, 5, 65535, 0);
        default: apply_config($urandom_range(2000), $urandom_range(2500),
                              $urandom_range(40), $urandom_range(12), $urandom_range(1));
      endcase
      for (int i = 0; i < 145; i++) begin
        if (p == 1 && i == 70) hold_request = 1'b1;
        if (p == 9 && i == 40) hold_request = 1'b1;
        if (p == 5 && i == 70) wait_drained();
        random_item();
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
